FILE: sv/wpsf_pkg.sv
// wpsf_pkg: shared types, codes and constants of the wav pcm stream formatter
// used by the front, queue and back modules; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package wpsf_pkg;

    localparam int HDR_LEN = 44;
    localparam int IDX_W = $clog2(HDR_LEN);

    // input item kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [11:0] MAX_SECONDS_RST = 12'd10;
    localparam logic [31:0] RIFF_EXTRA = 32'd36;

    // queued command codes
    typedef logic [2:0] op_t;
    localparam op_t OP_STATUS   = 3'd0;
    localparam op_t OP_ZERO_HDR = 3'd1;
    localparam op_t OP_WAV_HDR  = 3'd2;
    localparam op_t OP_MONO     = 3'd3;
    localparam op_t OP_STEREO   = 3'd4;

    typedef struct packed {
        op_t         op;
        logic        done;
        logic [15:0] left;
        logic [15:0] right;
        logic [18:0] rate;
        logic        stereo;
        logic [31:0] riff_size;
        logic [31:0] data_size;
    } cmd_t;

endpackage

`default_nettype wire

FILE: sv/wpsf_front.sv
// wpsf_front: accepts input items, keeps the capture state and queues commands
// depends on wpsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wpsf_front
    import wpsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        cfg_valid,
    input  wire logic [11:0] cfg_data,
    output logic             q_push,
    output cmd_t             q_cmd,
    input  wire logic        q_full
);

    logic        active_reg, active_next;
    logic [18:0] rate_reg, rate_next;
    logic        stereo_reg, stereo_next;
    logic [31:0] fc_reg, fc_next;
    logic [31:0] dc_reg, dc_next;
    logic        fin_reg, fin_next;
    logic [11:0] ms_reg;
    logic [30:0] limit_reg;
    logic        stale_reg, stale_next;

    logic [15:0] in_left;
    logic [15:0] in_right;
    logic        in_rpres;
    logic [3:0]  in_chans;
    logic [18:0] in_rate;
    logic        fire;
    logic        locking;
    logic        eff_stereo;
    logic [31:0] fc_inc;
    logic        at_limit;
    logic        inc_at_limit;

    assign in_left  = s_tdata[15:0];
    assign in_right = s_tdata[31:16];
    assign in_rpres = s_tdata[32];
    assign in_chans = s_tdata[36:33];
    assign in_rate  = s_tdata[55:37];

    // limit register is registered from the rate and config registers, so hold off input while it lags
    assign s_tready = !stale_reg && !q_full;
    assign fire     = s_tvalid && s_tready;
    assign q_push   = fire;

    assign locking      = (rate_reg == '0);
    assign eff_stereo   = locking ? (in_chans >= 4'd2) : stereo_reg;
    assign fc_inc       = fc_reg + 32'd1;
    assign at_limit     = (fc_reg >= {1'b0, limit_reg});
    assign inc_at_limit = (fc_inc >= {1'b0, limit_reg});

    always_comb
    begin
        active_next = active_reg;
        rate_next   = rate_reg;
        stereo_next = stereo_reg;
        fc_next     = fc_reg;
        dc_next     = dc_reg;
        fin_next    = fin_reg;
        stale_next  = cfg_valid;

        q_cmd           = '0;
        q_cmd.op        = OP_STATUS;
        q_cmd.left      = in_left;
        q_cmd.right     = (eff_stereo && in_rpres) ? in_right : in_left;
        q_cmd.rate      = rate_reg;
        q_cmd.stereo    = stereo_reg;
        q_cmd.riff_size = dc_reg + RIFF_EXTRA;
        q_cmd.data_size = dc_reg;
        q_cmd.done      = fin_reg || at_limit;

        case (s_tuser)
            KIND_START:
            begin
                active_next = 1'b1;
                rate_next   = '0;
                stereo_next = 1'b0;
                fc_next     = '0;
                dc_next     = '0;
                fin_next    = 1'b0;
                stale_next  = 1'b1;
                q_cmd.op    = OP_ZERO_HDR;
                // no rate locked, limit is zero
                q_cmd.done  = 1'b1;
            end
            KIND_SAMPLE:
            begin
                if (active_reg && in_chans != '0 && !fin_reg)
                begin
                    if (locking)
                    begin
                        // frame count is zero here, limit known without the product
                        rate_next   = in_rate;
                        stereo_next = eff_stereo;
                        stale_next  = 1'b1;
                        if (in_rate == '0 || ms_reg == '0)
                        begin
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            q_cmd.op = eff_stereo ? OP_STEREO : OP_MONO;
                            fc_next  = 32'd1;
                            dc_next  = eff_stereo ? 32'd4 : 32'd2;
                            fin_next = (in_rate == 19'd1) && (ms_reg == 12'd1);
                        end
                        q_cmd.done = fin_next;
                    end
                    else if (in_rate == rate_reg)
                    begin
                        if (at_limit)
                        begin
                            fin_next   = 1'b1;
                            q_cmd.done = 1'b1;
                        end
                        else
                        begin
                            q_cmd.op   = stereo_reg ? OP_STEREO : OP_MONO;
                            fc_next    = fc_inc;
                            dc_next    = dc_reg + (stereo_reg ? 32'd4 : 32'd2);
                            fin_next   = inc_at_limit;
                            q_cmd.done = inc_at_limit;
                        end
                    end
                end
            end
            KIND_FINISH:
            begin
                if (active_reg)
                begin
                    if (!locking)
                    begin
                        q_cmd.op = OP_WAV_HDR;
                    end
                    active_next = 1'b0;
                end
            end
            default:
            begin
                q_cmd.op = OP_STATUS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rate_reg   <= '0;
            stereo_reg <= 1'b0;
            fc_reg     <= '0;
            dc_reg     <= '0;
            fin_reg    <= 1'b0;
            ms_reg     <= MAX_SECONDS_RST;
            limit_reg  <= '0;
            stale_reg  <= 1'b0;
        end
        else
        begin
            limit_reg <= 31'(rate_reg) * 31'(ms_reg);
            stale_reg <= fire ? stale_next : cfg_valid;
            if (cfg_valid)
            begin
                ms_reg <= cfg_data;
            end
            if (fire)
            begin
                active_reg <= active_next;
                rate_reg   <= rate_next;
                stereo_reg <= stereo_next;
                fc_reg     <= fc_next;
                dc_reg     <= dc_next;
                fin_reg    <= fin_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/wpsf_queue.sv
// wpsf_queue: two-entry command queue between front and back
// depends on wpsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wpsf_queue
    import wpsf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/wpsf_back.sv
// wpsf_back: expands queued commands into output items, one item per cycle
// while the receiver takes them; depends on wpsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wpsf_back
    import wpsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire cmd_t       head_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic [IDX_W-1:0] idx_reg;
    logic             m_tvalid_reg;
    logic [7:0]       byte_reg;
    logic             done_reg;
    logic             bvalid_reg;
    logic             hdr_reg;
    logic             last_reg;

    logic             load;
    logic [IDX_W-1:0] len_m1;
    logic             is_last;
    logic [7:0]       cur_byte;
    logic             cur_bvalid;
    logic             cur_hdr;
    logic [7:0]       hdr_bytes [HDR_LEN];
    logic [31:0]      byte_rate;
    logic [7:0]       ch_num;

    assign ch_num    = head_cmd.stereo ? 8'd2 : 8'd1;
    assign byte_rate = head_cmd.stereo ? {11'd0, head_cmd.rate, 2'b00}
                                       : {12'd0, head_cmd.rate, 1'b0};

    always_comb
    begin
        hdr_bytes[0]  = 8'h52;
        hdr_bytes[1]  = 8'h49;
        hdr_bytes[2]  = 8'h46;
        hdr_bytes[3]  = 8'h46;
        hdr_bytes[4]  = head_cmd.riff_size[7:0];
        hdr_bytes[5]  = head_cmd.riff_size[15:8];
        hdr_bytes[6]  = head_cmd.riff_size[23:16];
        hdr_bytes[7]  = head_cmd.riff_size[31:24];
        hdr_bytes[8]  = 8'h57;
        hdr_bytes[9]  = 8'h41;
        hdr_bytes[10] = 8'h56;
        hdr_bytes[11] = 8'h45;
        hdr_bytes[12] = 8'h66;
        hdr_bytes[13] = 8'h6d;
        hdr_bytes[14] = 8'h74;
        hdr_bytes[15] = 8'h20;
        hdr_bytes[16] = 8'd16;
        hdr_bytes[17] = 8'd0;
        hdr_bytes[18] = 8'd0;
        hdr_bytes[19] = 8'd0;
        hdr_bytes[20] = 8'd1;
        hdr_bytes[21] = 8'd0;
        hdr_bytes[22] = ch_num;
        hdr_bytes[23] = 8'd0;
        hdr_bytes[24] = head_cmd.rate[7:0];
        hdr_bytes[25] = head_cmd.rate[15:8];
        hdr_bytes[26] = {5'd0, head_cmd.rate[18:16]};
        hdr_bytes[27] = 8'd0;
        hdr_bytes[28] = byte_rate[7:0];
        hdr_bytes[29] = byte_rate[15:8];
        hdr_bytes[30] = byte_rate[23:16];
        hdr_bytes[31] = byte_rate[31:24];
        hdr_bytes[32] = {ch_num[6:0], 1'b0};
        hdr_bytes[33] = 8'd0;
        hdr_bytes[34] = 8'd16;
        hdr_bytes[35] = 8'd0;
        hdr_bytes[36] = 8'h64;
        hdr_bytes[37] = 8'h61;
        hdr_bytes[38] = 8'h74;
        hdr_bytes[39] = 8'h61;
        hdr_bytes[40] = head_cmd.data_size[7:0];
        hdr_bytes[41] = head_cmd.data_size[15:8];
        hdr_bytes[42] = head_cmd.data_size[23:16];
        hdr_bytes[43] = head_cmd.data_size[31:24];
    end

    always_comb
    begin
        len_m1     = '0;
        cur_byte   = '0;
        cur_bvalid = 1'b1;
        cur_hdr    = 1'b0;
        case (head_cmd.op)
            OP_ZERO_HDR:
            begin
                len_m1  = IDX_W'(HDR_LEN - 1);
                cur_hdr = 1'b1;
            end
            OP_WAV_HDR:
            begin
                len_m1   = IDX_W'(HDR_LEN - 1);
                cur_hdr  = 1'b1;
                cur_byte = hdr_bytes[idx_reg];
            end
            OP_MONO:
            begin
                len_m1   = IDX_W'(1);
                cur_byte = idx_reg[0] ? head_cmd.left[15:8] : head_cmd.left[7:0];
            end
            OP_STEREO:
            begin
                len_m1 = IDX_W'(3);
                case (idx_reg[1:0])
                    2'd0:    cur_byte = head_cmd.left[7:0];
                    2'd1:    cur_byte = head_cmd.left[15:8];
                    2'd2:    cur_byte = head_cmd.right[7:0];
                    default: cur_byte = head_cmd.right[15:8];
                endcase
            end
            default:
            begin
                cur_bvalid = 1'b0;
            end
        endcase
    end

    assign is_last = (idx_reg == len_m1);
    assign load    = head_valid && (!m_tvalid_reg || m_tready);
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= is_last ? '0 : idx_reg + IDX_W'(1);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= cur_byte;
            done_reg   <= head_cmd.done;
            bvalid_reg <= cur_bvalid;
            hdr_reg    <= cur_hdr;
            last_reg   <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, done_reg, byte_reg};
    assign m_tuser  = {hdr_reg, bvalid_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: sv/wav_pcm_stream_formatter.sv
// wav_pcm_stream_formatter: top level, formats 16-bit pcm items into wav file bytes
// depends on wpsf_pkg, wpsf_front, wpsf_queue, wpsf_back
//
// usage
//   slave channel (s_*) takes one item per handshake: tuser is the kind
//   (start, sample, finish), tdata the sample fields, tlast the frame marker
//   master channel (m_*) gives one file byte or one status item per handshake;
//   tlast marks the final output item caused by an input item
//   cfg channel writes max_seconds and is always ready; the user must write it
//   only while idle, which the block itself does not enforce
// an accepted input item is queued, then loaded into the output register
// throughput: one output item per cycle while the receiver is ready; a mono
//   sample gives 2 bytes, a stereo sample 4, start and a finish that writes the
//   header 44, any other item a single status item; the back end sets that rate
// after a start item, the first locking sample, or a config write the input is
//   held off while the frame limit product is re-registered
// reset clears the capture state, sets max_seconds to 10 and empties the queue
// a stalled receiver holds the output register; the two-entry command queue
//   keeps accepting until it fills, then s_tready drops
`timescale 1ns / 1ps
`default_nettype none

module wav_pcm_stream_formatter
    import wpsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] left_sample, [31:16] right_sample, [32] right_present,
    // [36:33] channel_count, [55:37] sample_rate
    input  wire logic [55:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    // frame_last, informational only
    input  wire logic        s_tlast,
    // output items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte, [8] capture_done, [15:9] zero
    output logic [15:0]      m_tdata,
    // [0] byte_valid, [1] is_header
    output logic [1:0]       m_tuser,
    // last
    output logic             m_tlast,
    // max_seconds write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    // register writes never stall
    assign cfg_ready = 1'b1;

    wpsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_push    (push),
        .q_cmd     (push_cmd),
        .q_full    (full)
    );

    wpsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    wpsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: sv/wpsf_checker.sv
// wpsf_checker: port-level assertions for the wav pcm stream formatter
// depends on wpsf_pkg; bound to wav_pcm_stream_formatter
`timescale 1ns / 1ps
`default_nettype none

module wpsf_checker
    import wpsf_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output item changed while stalled");

    // a status-only item is a lone item with a zero byte
    a_status_lone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0) && !m_tuser[1])
        else $error("status item not last or carries a byte");

    // a start item forces the frame limit refresh cycle
    a_start_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_START) |=> !s_tready)
        else $error("input accepted right after a start item");

    // config write also forces the refresh cycle
    a_cfg_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input accepted right after a config write");

endmodule

bind wav_pcm_stream_formatter wpsf_checker u_wpsf_checker (.*);

`default_nettype wire

FILE: tb/wav_pcm_stream_formatter_tb.sv
// wav_pcm_stream_formatter_tb: self-checking bench for the wav pcm stream formatter,
// a queue-fed driver, a byte monitor and an item-order model of the file bytes
// depends on wpsf_pkg and wav_pcm_stream_formatter
`timescale 1ns / 1ps

module wav_pcm_stream_formatter_tb;
    import wpsf_pkg::*;

    // kind code the block must ignore
    localparam logic [1:0] KIND_RSVD = 2'd3;
    localparam int unsigned TIMEOUT_CYCLES = 5_000_000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_AT_ITEM = 120;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 70;

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";

    // one input item as the block sees it
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] left;
        logic [15:0] right;
        logic        rpres;
        logic [3:0]  chans;
        logic [18:0] rate;
        logic        flast;
    } in_item_t;

    // one output item: file byte plus flags
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       hdr;
        logic       done;
        logic       last;
    } out_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [15:0] m_tdata;
    wire logic [1:0]  m_tuser;
    wire logic   m_tlast;
    logic        cfg_valid = 1'b0;
    wire logic   cfg_ready;
    logic [11:0] cfg_data = '0;

    wav_pcm_stream_formatter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // model state of the formatter
    // ------------------------------------------------------------------
    logic [11:0] max_sec = MAX_SECONDS_RST;
    logic        cap_on = 1'b0;
    logic [18:0] lock_rate = '0;
    logic        stereo = 1'b0;
    logic [31:0] frames = '0;
    logic [33:0] data_bytes = '0;
    logic        closed = 1'b0;

    // scratch for the bytes one input item produces
    out_item_t   step_out [0:HDR_LEN-1];
    int          step_n;
    logic [7:0]  hdr_img [0:HDR_LEN-1];

    in_item_t    pend_items [$];   // items waiting for the driver
    out_item_t   due_bytes [$];    // file bytes and status items still to arrive
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned errors = 0;
    int unsigned cyc = 0;
    int unsigned hold_left = 0;
    logic        hold_armed = 1'b1;

    // frame limit reached, with the limit as a full 64-bit product
    function automatic logic limit_hit();
        logic [63:0] a;
        logic [63:0] b;
        a = 64'(lock_rate);
        b = 64'(max_sec);
        limit_hit = ({32'd0, frames} >= a * b);
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic is_hdr);
        step_out[step_n] = '{data: b, valid: 1'b1, hdr: is_hdr, done: 1'b0, last: 1'b0};
        step_n++;
    endfunction

    function automatic void put_le32(input int idx, input logic [31:0] v);
        hdr_img[idx]     = v[7:0];
        hdr_img[idx + 1] = v[15:8];
        hdr_img[idx + 2] = v[23:16];
        hdr_img[idx + 3] = v[31:24];
    endfunction

    // four-character tags go out in reading order
    function automatic void put_tag(input int idx, input logic [31:0] tag);
        hdr_img[idx]     = tag[31:24];
        hdr_img[idx + 1] = tag[23:16];
        hdr_img[idx + 2] = tag[15:8];
        hdr_img[idx + 3] = tag[7:0];
    endfunction

    // apply one accepted item to the model and queue the bytes it causes
    function automatic void wav_format_item(input in_item_t it);
        logic [15:0] second;
        logic [31:0] nch;
        logic [31:0] dsz;
        logic        done;
        step_n = 0;
        case (it.kind)
            KIND_START:
            begin
                // also a restart when a capture is already running
                cap_on = 1'b1;
                lock_rate = '0;
                stereo = 1'b0;
                frames = '0;
                data_bytes = '0;
                closed = 1'b0;
                for (int i = 0; i < HDR_LEN; i++)
                    emit_byte(8'h00, 1'b1);
            end
            KIND_SAMPLE:
            begin
                if (cap_on && it.chans != 4'd0 && !closed)
                begin
                    // first sample locks rate and mode; a zero rate locks nothing
                    if (lock_rate == 19'd0)
                    begin
                        lock_rate = it.rate;
                        stereo = (it.chans >= 4'd2);
                    end
                    if (lock_rate == it.rate)
                    begin
                        if (limit_hit())
                            closed = 1'b1;
                        else
                        begin
                            emit_byte(it.left[7:0], 1'b0);
                            emit_byte(it.left[15:8], 1'b0);
                            if (stereo)
                            begin
                                second = it.rpres ? it.right : it.left;
                                emit_byte(second[7:0], 1'b0);
                                emit_byte(second[15:8], 1'b0);
                            end
                            data_bytes = data_bytes + 34'(step_n);
                            frames = frames + 1;
                            if (limit_hit())
                                closed = 1'b1;
                        end
                    end
                end
            end
            KIND_FINISH:
            begin
                if (cap_on)
                begin
                    if (lock_rate != 19'd0)
                    begin
                        nch = stereo ? 32'd2 : 32'd1;
                        dsz = data_bytes[31:0];
                        for (int i = 0; i < HDR_LEN; i++)
                            hdr_img[i] = 8'h00;
                        put_tag(0, TAG_RIFF);
                        put_le32(4, RIFF_EXTRA + dsz);
                        put_tag(8, TAG_WAVE);
                        put_tag(12, TAG_FMT);
                        put_le32(16, 32'd16);
                        hdr_img[20] = 8'd1;
                        hdr_img[22] = nch[7:0];
                        put_le32(24, {13'd0, lock_rate});
                        put_le32(28, {13'd0, lock_rate} * nch * 32'd2);
                        hdr_img[32] = nch[7:0] * 8'd2;
                        hdr_img[34] = 8'd16;
                        put_tag(36, TAG_DATA);
                        put_le32(40, dsz);
                        for (int i = 0; i < HDR_LEN; i++)
                            emit_byte(hdr_img[i], 1'b1);
                    end
                    cap_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        // items with no byte still give one status item
        if (step_n == 0)
        begin
            step_out[0] = '{data: 8'h00, valid: 1'b0, hdr: 1'b0, done: 1'b0, last: 1'b0};
            step_n = 1;
        end
        done = closed || limit_hit();
        for (int i = 0; i < step_n; i++)
        begin
            step_out[i].done = done;
            step_out[i].last = (i == step_n - 1);
            due_bytes.push_back(step_out[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t mk_item(input logic [1:0] kind, input logic [15:0] left,
                                         input logic [15:0] right, input logic rpres,
                                         input logic [3:0] chans, input logic [18:0] rate,
                                         input logic flast);
        mk_item = '{kind: kind, left: left, right: right, rpres: rpres, chans: chans,
                    rate: rate, flast: flast};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            idle_len = 0;
        else if (r < 95)
            idle_len = $urandom_range(1, 3);
        else
            idle_len = $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_pcm();
        case ($urandom_range(0, 15))
            0: pick_pcm = 16'h8000;
            1: pick_pcm = 16'h7FFF;
            2: pick_pcm = 16'h0000;
            3: pick_pcm = 16'hFFFF;
            default: pick_pcm = 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // small rates let the frame limit come into reach
    function automatic logic [18:0] pick_rate();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            pick_rate = 19'($urandom_range(1, 6));
        else if (r < 75)
        begin
            case ($urandom_range(0, 4))
                0: pick_rate = 19'd8000;
                1: pick_rate = 19'd22050;
                2: pick_rate = 19'd44100;
                3: pick_rate = 19'd48000;
                default: pick_rate = 19'd384000;
            endcase
        end
        else if (r < 90)
            pick_rate = 19'($urandom_range(1, 384000));
        else if (r < 97)
            pick_rate = 19'($urandom_range(0, 19'h7FFFF));
        else
            pick_rate = 19'd0;
    endfunction

    function automatic logic [3:0] pick_chans();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            pick_chans = 4'd1;
        else if (r < 85)
            pick_chans = 4'd2;
        else if (r < 95)
            pick_chans = 4'($urandom_range(3, 8));
        else
            pick_chans = 4'($urandom_range(9, 15));
    endfunction

    function automatic in_item_t rand_noise();
        rand_noise = mk_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                             16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                             4'($urandom_range(0, 15)), 19'($urandom_range(0, 19'h7FFFF)),
                             1'($urandom_range(0, 1)));
    endfunction

    task automatic queue_item(input in_item_t it);
        pend_items.push_back(it);
        items_queued++;
    endtask

    // sometimes a noise item, then start, a run of samples at one rate with some broken ones, usually a finish
    task automatic queue_capture();
        logic [18:0] rate;
        logic [3:0]  ch;
        int unsigned len;
        int unsigned r;
        in_item_t    it;
        rate = pick_rate();
        ch = pick_chans();
        len = $urandom_range(2, 14);
        if ($urandom_range(0, 9) == 0)
            queue_item(rand_noise());
        queue_item(mk_item(KIND_START, pick_pcm(), pick_pcm(), 1'($urandom_range(0, 1)),
                           4'($urandom_range(0, 15)), 19'($urandom_range(0, 19'h7FFFF)),
                           1'b0));
        for (int k = 0; k < len; k++)
        begin
            it = mk_item(KIND_SAMPLE, pick_pcm(), pick_pcm(), 1'($urandom_range(0, 1)), ch,
                         rate, 1'($urandom_range(0, 1)));
            r = $urandom_range(0, 99);
            if (r < 8)
                it.rate = pick_rate();
            else if (r < 12)
                it.chans = 4'd0;
            else if (r < 14)
                it.kind = KIND_RSVD;
            else if (r < 16)
                it = rand_noise();
            queue_item(it);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            it = rand_noise();
            it.kind = KIND_FINISH;
            queue_item(it);
        end
    endtask

    // wait until every queued item is taken and every byte has come back
    task automatic drain();
        while (items_taken != items_queued || due_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // max_seconds is only written with the block idle
    task automatic write_max_seconds(input logic [11:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_sec = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic log_mismatch(input string what, input out_item_t want, input out_item_t got);
        if (errors < 10)
        begin
            $write("%0t %s: expected byte %02h valid %b hdr %b done %b last %b, ",
                   $realtime, what, want.data, want.valid, want.hdr, want.done, want.last);
            $display("got byte %02h valid %b hdr %b done %b last %b",
                     got.data, got.valid, got.hdr, got.done, got.last);
        end
        errors++;
    endtask

    // ------------------------------------------------------------------
    // input driver: presents queued items, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic        vnext;
        in_item_t    it;
        int unsigned gap;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap = 0;
        end
        else
        begin
            vnext = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                // item accepted at this edge: update the model right away
                wav_format_item({s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[32],
                                 s_tdata[36:33], s_tdata[55:37], s_tlast});
                items_taken++;
                vnext = 1'b0;
            end
            if (!vnext)
            begin
                if (gap > 0)
                    gap--;
                else if (pend_items.size() > 0)
                begin
                    it = pend_items.pop_front();
                    s_tdata <= {it.rate, it.chans, it.rpres, it.right, it.left};
                    s_tuser <= it.kind;
                    s_tlast <= it.flast;
                    vnext = 1'b1;
                    // every other run of 64 items goes back to back
                    gap = items_taken[6] ? 0 : idle_len();
                end
            end
            s_tvalid <= vnext;
        end
    end

    // one long receiver hold-off while the sender keeps offering items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && items_taken >= HOLD_AT_ITEM)
        begin
            hold_left <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // output monitor: checks each item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        out_item_t   got;
        out_item_t   want;
        int unsigned stall;
        int unsigned n;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall = 0;
        end
        else
        begin
            cyc++;
            if (m_tvalid && m_tready)
            begin
                got = '{data: m_tdata[7:0], valid: m_tuser[0], hdr: m_tuser[1],
                        done: m_tdata[8], last: m_tlast};
                if (due_bytes.size() == 0)
                    log_mismatch("unexpected output item", '0, got);
                else
                begin
                    want = due_bytes.pop_front();
                    if (got.data !== want.data || got.valid !== want.valid ||
                        got.hdr !== want.hdr || got.done !== want.done ||
                        got.last !== want.last)
                        log_mismatch("mismatch", want, got);
                end
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                // alternate stretches, chosen by bit 8 of the cycle counter, with the receiver always ready
                n = cyc[8] ? 0 : idle_len();
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    stall = n - 1;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed cases, random phases at several limits
    // ------------------------------------------------------------------
    initial
    begin : main_proc
        logic [11:0] limits [0:5];
        int unsigned first;
        limits[0] = 12'd3600;
        limits[1] = 12'd1;
        limits[2] = 12'd2;
        limits[3] = 12'($urandom_range(1, 3600));
        limits[4] = 12'd10;
        limits[5] = 12'd3;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sample and finish while idle, then the reserved kind
        queue_item(mk_item(KIND_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b1, 4'hF, 19'h7FFFF, 1'b1));
        queue_item(mk_item(KIND_FINISH, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        queue_item(mk_item(KIND_RSVD, 16'h8000, 16'h7FFF, 1'b1, 4'h2, 19'd48000, 1'b1));
        // finish with no rate locked: closes without a header
        queue_item(mk_item(KIND_START, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        queue_item(mk_item(KIND_FINISH, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        // zero channel count ignored, zero rate closes, later sample ignored
        queue_item(mk_item(KIND_START, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h1234, 16'h5678, 1'b1, 4'h0, 19'd8000, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h1234, 16'h5678, 1'b1, 4'h1, 19'd0, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'hABCD, 16'h5678, 1'b1, 4'h1, 19'd0, 1'b1));
        queue_item(mk_item(KIND_FINISH, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        // mono at rate 1, off-rate sample dropped, mode stays mono
        queue_item(mk_item(KIND_START, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h8000, 16'hFFFF, 1'b1, 4'h1, 19'd1, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h7FFF, 16'h0000, 1'b0, 4'h1, 19'd1, 1'b1));
        queue_item(mk_item(KIND_SAMPLE, 16'h5555, 16'hAAAA, 1'b1, 4'h1, 19'd2, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'hAAAA, 16'h5555, 1'b1, 4'h2, 19'd1, 1'b0));
        queue_item(mk_item(KIND_FINISH, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        drain();
        write_max_seconds(12'd1);

        // stereo at rate 2 with one-second limit: second sample reaches the limit, third is ignored
        queue_item(mk_item(KIND_START, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h0000, 16'hFFFF, 1'b1, 4'h2, 19'd2, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h1234, 16'h5678, 1'b0, 4'h2, 19'd2, 1'b1));
        queue_item(mk_item(KIND_SAMPLE, 16'h9ABC, 16'hDEF0, 1'b1, 4'h2, 19'd2, 1'b0));
        queue_item(mk_item(KIND_FINISH, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        // restart while active, widest rate and channel count
        queue_item(mk_item(KIND_START, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h0102, 16'h0304, 1'b1, 4'h8, 19'd384000, 1'b0));
        queue_item(mk_item(KIND_START, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));
        queue_item(mk_item(KIND_SAMPLE, 16'h8000, 16'h8000, 1'b1, 4'hF, 19'h7FFFF, 1'b1));
        queue_item(mk_item(KIND_FINISH, 16'h0000, 16'h0000, 1'b0, 4'h0, 19'd0, 1'b0));

        // random phases; the sender pauses at each boundary until all bytes are back
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_max_seconds(limits[p]);
            first = items_queued;
            while (items_queued - first < PHASE_ITEMS)
                queue_capture();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_bytes.size() != 0)
            errors++;
        if (errors == 0)
            $display("** wav_pcm_stream_formatter: PASSED **");
        else
            $display("** wav_pcm_stream_formatter: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("** wav_pcm_stream_formatter: FAILED **");
        $finish;
    end

endmodule
